// ===== design/pedq_pkg.sv =====
`default_nettype none
package pedq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OCC_W     = 5;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_POP_FRONT = 2'd1,
        OP_POP_REAR  = 2'd2,
        OP_LIST      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_PUT_FRONT = 3'd0,
        STS_PUT_REAR  = 3'd1,
        STS_REJECT    = 3'd2,
        STS_FULL      = 3'd3,
        STS_POPPED    = 3'd4,
        STS_EMPTY     = 3'd5,
        STS_LISTED    = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LIST
    } state_t;

    // What every cell of the row does when it is clocked
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_REAR,
        CELL_SHIFT_LEFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] time_val;
        logic [7:0]  prio;
    } job_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] job_tag;
        logic [15:0] job_time;
        logic [7:0]  job_prio;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [15:0]      out_tag;
        logic [15:0]      out_time;
        logic [7:0]       out_priority;
        logic             last;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

endpackage
`default_nettype wire

// ===== design/pedq_cell.sv =====
`default_nettype none
module pedq_cell
    import pedq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
)
(
    input  wire logic                       clk,
    input  wire cell_op_t                   op,
    input  wire logic [$clog2(DEPTH+1)-1:0] count,
    input  wire job_t                       new_job,
    input  wire job_t                       left_job,
    input  wire job_t                       right_job,
    input  wire job_t                       front_job,
    output job_t                            job,
    output job_t                            tail_job
);

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    job_t job_reg;
    job_t job_next;
    logic is_tail;

    assign is_tail = (count == IDX_P1);

    always_comb
    begin
        job_next = job_reg;
        case (op)
            CELL_HOLD:
            begin
                job_next = job_reg;
            end
            CELL_PUSH_FRONT:
            begin
                job_next = (INDEX == 0) ? new_job : left_job;
            end
            CELL_PUSH_REAR:
            begin
                if (count == IDX)
                begin
                    job_next = new_job;
                end
            end
            CELL_SHIFT_LEFT:
            begin
                job_next = right_job;
            end
            CELL_ROTATE:
            begin
                // the front item wraps round to the rear slot
                if (is_tail)
                begin
                    job_next = front_job;
                end
                else if (IDX_P1 < count)
                begin
                    job_next = right_job;
                end
            end
            default:
            begin
                job_next = job_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job      = job_reg;
    assign tail_job = is_tail ? job_reg : '0;

endmodule
`default_nettype wire

// ===== design/priority_end_insert_deque_core.sv =====
`default_nettype none
// Priority end-insert deque.
// Request channel: req is taken at a rising edge where start is high and busy
// is low. Insert goes to the front if its priority is at least the front
// item's, else to the rear if at most the rear's, else rejected (STS_FULL if full).
// Result channel: rsp is valid for exactly one cycle while strobe is high;
// the receiver cannot stall it, so no result is ever held back.
// The result of insert, pop or an empty list appears in the cycle after the
// request is taken, and busy stays low, so one request per cycle.
// A list of a non-empty deque raises busy while it walks the items; results
// follow one per cycle, the first once the list state has been entered and
// its result registered, the last marked by rsp.last. The next request can
// be taken in the cycle the last list result is shown.
// The items sit in a row of DEPTH cells with the front in cell 0; list
// rotates the occupied cells once round.
// Reset clears the fill count, state and strobe; cell contents are not reset.
module priority_end_insert_deque_core
    import pedq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      strobe,
    output rsp_t      rsp
);

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic             strobe_reg;
    logic             strobe_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    cell_op_t cell_op;
    job_t     new_job;
    job_t     cell_job [DEPTH];
    job_t     cell_tail [DEPTH];
    job_t     front_job;
    job_t     tail_job;
    job_t     out_job;
    status_t  sts;
    logic     out_last;
    logic     accept;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign new_job = '{tag: req.job_tag, time_val: req.job_time, prio: req.job_prio};
    assign front_job = cell_job[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pedq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .count     (count_reg),
            .new_job   (new_job),
            .left_job  (cell_job[(i == 0) ? 0 : i - 1]),
            .right_job (cell_job[(i == DEPTH - 1) ? i : i + 1]),
            .front_job (front_job),
            .job       (cell_job[i]),
            .tail_job  (cell_tail[i])
        );
    end

    // only the tail cell drives a non-zero value
    always_comb
    begin
        tail_job = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_job = tail_job | cell_tail[i];
        end
    end

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        strobe_next = 1'b0;
        cell_op     = CELL_HOLD;
        sts         = STS_EMPTY;
        out_job     = '0;
        out_last    = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (req.op)
                        OP_INSERT:
                        begin
                            if (count_reg == '0)
                            begin
                                cell_op    = CELL_PUSH_REAR;
                                count_next = ONE_CNT;
                                sts        = STS_PUT_FRONT;
                            end
                            else if (count_reg >= FULL_CNT)
                            begin
                                sts = STS_FULL;
                            end
                            else if (req.job_prio >= front_job.prio)
                            begin
                                cell_op    = CELL_PUSH_FRONT;
                                count_next = count_reg + ONE_CNT;
                                sts        = STS_PUT_FRONT;
                            end
                            else if (req.job_prio <= tail_job.prio)
                            begin
                                cell_op    = CELL_PUSH_REAR;
                                count_next = count_reg + ONE_CNT;
                                sts        = STS_PUT_REAR;
                            end
                            else
                            begin
                                sts = STS_REJECT;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                cell_op    = CELL_SHIFT_LEFT;
                                count_next = count_reg - ONE_CNT;
                                sts        = STS_POPPED;
                                out_job    = front_job;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - ONE_CNT;
                                sts        = STS_POPPED;
                                out_job    = tail_job;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg != '0)
                            begin
                                strobe_next = 1'b0;
                                remain_next = count_reg;
                                state_next  = ST_LIST;
                            end
                        end
                        default:
                        begin
                            sts = STS_EMPTY;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                strobe_next = 1'b1;
                cell_op     = CELL_ROTATE;
                sts         = STS_LISTED;
                out_job     = front_job;
                out_last    = (remain_reg == ONE_CNT);
                remain_next = remain_reg - ONE_CNT;
                if (remain_reg == ONE_CNT)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.status       = sts;
        rsp_next.out_tag      = out_job.tag;
        rsp_next.out_time     = out_job.time_val;
        rsp_next.out_priority = out_job.prio;
        rsp_next.last         = out_last;
        rsp_next.occupancy    = occ_wide[OCC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg == ST_LIST);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0) && (remain_reg != '0) && (remain_reg <= count_reg))
        else $error("list walk with bad remaining count");

    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && remain_reg == ONE_CNT) |=> strobe && rsp.last && !busy)
        else $error("list did not finish with a last item");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op != OP_LIST) |=> strobe && rsp.last && !busy)
        else $error("single-result request gave no last item");

    a_list_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && remain_reg != ONE_CNT) |=> strobe && !rsp.last && busy)
        else $error("list item wrongly marked last");
`endif

endmodule
`default_nettype wire
